@@ design/dpfs_pkg.sv @@
// Shared types, constants and register codes for the delimited packet frame sync block.
`default_nettype none

package dpfs_pkg;

  // Default geometry of a packet
  localparam int PACKET_BYTES = 512;
  localparam int HEADER_BYTES = 2;
  localparam int STAMP_BYTES  = 12;

  // Timestamp layout: 8 bytes of seconds then 4 bytes of nanoseconds
  localparam int SECS_BYTES  = 8;
  localparam int NANOS_BYTES = 4;
  localparam int STAMP_TAPS  = SECS_BYTES + NANOS_BYTES;
  localparam int SECS_W      = 8 * SECS_BYTES;
  localparam int NANOS_W     = 8 * NANOS_BYTES;

  // Divide by 1000 as multiply by reciprocal; exact for every 32-bit value
  localparam int               MAGIC_W   = 29;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
  localparam int               DIV_SHIFT = 38;
  localparam int               PROD_W    = NANOS_W + MAGIC_W;
  localparam int               MICROS_W  = 23;

  // Delimiter reset values
  localparam logic [15:0] START_RESET = 16'hB255;
  localparam logic [15:0] END_RESET   = 16'h759F;

  // Stream word layout
  localparam int OFFSET_W = 12;
  localparam int FIELDS_W = 1 + SECS_W + MICROS_W + 8 + OFFSET_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;
  localparam int TUSER_W  = 4;

  typedef logic [7:0]          byte_t;
  typedef logic [OFFSET_W-1:0] offset_t;

  // Register index codes, taken from paddr[2]
  typedef enum logic {
    REG_START = 1'b0,
    REG_END   = 1'b1
  } reg_idx_t;

  // Tags of the byte that leaves the window
  typedef struct packed {
    logic    valid;
    logic    in_packet;
    offset_t offset;
    logic    payload;
    logic    first;
    logic    last;
  } tag_t;

endpackage

`default_nettype wire

@@ design/dpfs_cell.sv @@
// One byte cell of the sliding window shift line.
`default_nettype none

module dpfs_cell (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire dpfs_pkg::byte_t d,
  output dpfs_pkg::byte_t    q
);

  // Take the neighbor's byte on every accepted word
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

@@ design/dpfs_ctrl.sv @@
// Fill, check and exit counters that tag leaving bytes and gate the delimiter check.
`default_nettype none

module dpfs_ctrl #(
  parameter int PACKET_BYTES = dpfs_pkg::PACKET_BYTES,
  parameter int HEADER_BYTES = dpfs_pkg::HEADER_BYTES,
  parameter int STAMP_BYTES  = dpfs_pkg::STAMP_BYTES
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      advance,
  input  wire logic      match,
  output logic           hit,
  output dpfs_pkg::tag_t tag
);

  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(PACKET_BYTES);
  localparam int PAY_LO = HEADER_BYTES + STAMP_BYTES;
  localparam int PAY_HI = PACKET_BYTES - 2;

  logic [CW-1:0] fill_cnt, fill_cnt_next;
  logic [CW-1:0] since_cnt, since_cnt_next;
  logic [CW-1:0] exit_cnt, exit_cnt_next;
  logic [CW-1:0] since_inc;
  logic [CW-1:0] leave_pos;
  logic          full;
  logic          in_pk;

  // Tag the leaving byte and decide the check for this word
  always_comb begin
    full      = (fill_cnt == FULL_CNT);
    in_pk     = full && (exit_cnt != '0);
    leave_pos = FULL_CNT - exit_cnt;

    tag.valid     = full;
    tag.in_packet = in_pk;
    tag.offset    = in_pk ? dpfs_pkg::offset_t'(leave_pos) : '0;
    tag.payload   = in_pk && (int'(leave_pos) >= PAY_LO) && (int'(leave_pos) < PAY_HI);
    tag.first     = in_pk && (leave_pos == '0);
    tag.last      = in_pk && (leave_pos == FULL_CNT - 1'b1);

    fill_cnt_next = full ? FULL_CNT : fill_cnt + 1'b1;
    since_inc     = (since_cnt == FULL_CNT) ? since_cnt : since_cnt + 1'b1;
    hit           = (fill_cnt_next == FULL_CNT) && (since_inc == FULL_CNT) && match;

    since_cnt_next = hit ? '0 : since_inc;
    if (hit) begin
      exit_cnt_next = FULL_CNT;
    end else if (in_pk) begin
      exit_cnt_next = exit_cnt - 1'b1;
    end else begin
      exit_cnt_next = exit_cnt;
    end
  end

  // Advance the counters on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt  <= '0;
      since_cnt <= '0;
      exit_cnt  <= '0;
    end else if (advance) begin
      fill_cnt  <= fill_cnt_next;
      since_cnt <= since_cnt_next;
      exit_cnt  <= exit_cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ design/delimited_packet_frame_sync.sv @@
// An accepted input word passes stage 1, stage 2 and the output register to its result word.
// Throughput: one byte per cycle unless the output stalls; the window is a shift line of
//   PACKET_BYTES byte cells, fixed taps; the divide by 1000 is a registered multiply stage.
// One result word per input word; the first PACKET_BYTES results carry no leaving byte.
// Reset: counters and pipeline valids clear, delimiters return to B255 and 759F;
//   window cells are not cleared and take no clearing pass.
`default_nettype none

module delimited_packet_frame_sync #(
  parameter int PACKET_BYTES = dpfs_pkg::PACKET_BYTES,
  parameter int HEADER_BYTES = dpfs_pkg::HEADER_BYTES,
  parameter int STAMP_BYTES  = dpfs_pkg::STAMP_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // in_byte[7:0]
  // Output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // found[0], stamp_seconds[64:1], stamp_micros[87:65], out_byte[95:88],
  // byte_offset[107:96], zero pad[111:108]
  output logic [dpfs_pkg::TDATA_W-1:0]       m_tdata,
  // out_valid[0], in_packet[1], is_payload[2], packet_first[3]
  output logic [dpfs_pkg::TUSER_W-1:0]       m_tuser,
  output logic                               m_tlast,   // packet_last
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // ---------------------------------------------------------------- config
  logic [15:0] start_delim;
  logic [15:0] end_delim;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write a delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_delim <= dpfs_pkg::START_RESET;
      end_delim   <= dpfs_pkg::END_RESET;
    end else if (cfg_wr) begin
      unique case (dpfs_pkg::reg_idx_t'(paddr[2]))
        dpfs_pkg::REG_START: start_delim <= pwdata[15:0];
        dpfs_pkg::REG_END:   end_delim   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back a delimiter register
  always_comb begin
    unique case (dpfs_pkg::reg_idx_t'(paddr[2]))
      dpfs_pkg::REG_START: prdata = {16'b0, start_delim};
      dpfs_pkg::REG_END:   prdata = {16'b0, end_delim};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic in_accept;

  assign rdy3      = !v3 || m_tready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign s_tready  = rdy1;
  assign in_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------- window cells
  dpfs_pkg::byte_t cell_q [PACKET_BYTES];

  for (genvar i = 0; i < PACKET_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      dpfs_cell u_cell (
        .clk   (clk),
        .shift (in_accept),
        .d     (s_tdata),
        .q     (cell_q[i])
      );
    end else begin : g_body
      dpfs_cell u_cell (
        .clk   (clk),
        .shift (in_accept),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  // Window after this word enters: position p sits in cell P-2-p, the newest is s_tdata
  dpfs_pkg::byte_t stamp_tap [dpfs_pkg::STAMP_TAPS];

  for (genvar k = 0; k < dpfs_pkg::STAMP_TAPS; k++) begin : g_tap
    localparam int POS = HEADER_BYTES + k;
    if (POS <= PACKET_BYTES - 2) begin : g_cell_tap
      assign stamp_tap[k] = cell_q[PACKET_BYTES - 2 - POS];
    end else if (POS == PACKET_BYTES - 1) begin : g_new_tap
      assign stamp_tap[k] = s_tdata;
    end else begin : g_zero_tap
      assign stamp_tap[k] = '0;
    end
  end

  logic                         match;
  logic [dpfs_pkg::SECS_W-1:0]  secs_raw;
  logic [dpfs_pkg::NANOS_W-1:0] nanos_raw;

  // Compare delimiters and gather timestamp bytes, little endian
  always_comb begin
    match = (cell_q[PACKET_BYTES-2] == start_delim[15:8]) &&
            (cell_q[PACKET_BYTES-3] == start_delim[7:0]) &&
            (cell_q[0]              == end_delim[15:8]) &&
            (s_tdata                == end_delim[7:0]);
    for (int k = 0; k < dpfs_pkg::SECS_BYTES; k++) begin
      secs_raw[8*k +: 8] = stamp_tap[k];
    end
    for (int k = 0; k < dpfs_pkg::NANOS_BYTES; k++) begin
      nanos_raw[8*k +: 8] = stamp_tap[dpfs_pkg::SECS_BYTES + k];
    end
  end

  // ---------------------------------------------------------------- control
  logic           hit;
  dpfs_pkg::tag_t tag;

  dpfs_ctrl #(
    .PACKET_BYTES (PACKET_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .STAMP_BYTES  (STAMP_BYTES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (in_accept),
    .match   (match),
    .hit     (hit),
    .tag     (tag)
  );

  // ---------------------------------------------------------------- stage 1
  logic                         p1_found;
  logic [dpfs_pkg::SECS_W-1:0]  p1_secs;
  logic [dpfs_pkg::NANOS_W-1:0] p1_nanos;
  dpfs_pkg::byte_t              p1_byte;
  dpfs_pkg::tag_t               p1_tag;

  // Capture the check result and the leaving byte
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_found <= hit;
      p1_secs  <= hit ? secs_raw : '0;
      p1_nanos <= hit ? nanos_raw : '0;
      p1_byte  <= tag.valid ? cell_q[PACKET_BYTES-1] : '0;
      p1_tag   <= tag;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                         p2_found;
  logic [dpfs_pkg::SECS_W-1:0]  p2_secs;
  logic [dpfs_pkg::PROD_W-1:0]  p2_prod;
  dpfs_pkg::byte_t              p2_byte;
  dpfs_pkg::tag_t               p2_tag;

  // Multiply nanoseconds by the reciprocal of 1000
  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_found <= p1_found;
      p2_secs  <= p1_secs;
      p2_prod  <= dpfs_pkg::PROD_W'(p1_nanos) * dpfs_pkg::PROD_W'(dpfs_pkg::DIV_MAGIC);
      p2_byte  <= p1_byte;
      p2_tag   <= p1_tag;
    end
  end

  // ---------------------------------------------------------------- output register
  logic                          o_found;
  logic [dpfs_pkg::SECS_W-1:0]   o_secs;
  logic [dpfs_pkg::MICROS_W-1:0] o_micros;
  dpfs_pkg::byte_t               o_byte;
  dpfs_pkg::tag_t                o_tag;

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rdy3) begin
      o_found  <= p2_found;
      o_secs   <= p2_secs;
      o_micros <= p2_prod[dpfs_pkg::DIV_SHIFT +: dpfs_pkg::MICROS_W];
      o_byte   <= p2_byte;
      o_tag    <= p2_tag;
    end
  end

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {{dpfs_pkg::PAD_W{1'b0}}, o_tag.offset, o_byte, o_micros, o_secs, o_found};
  assign m_tuser  = {o_tag.first, o_tag.payload, o_tag.in_packet, o_tag.valid};
  assign m_tlast  = o_tag.last;

  // ---------------------------------------------------------------- checks
  // Input stalls only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3))
    else $error("input stalled with a free pipeline stage");

  // A word in stage one that cannot move stays there
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> v1)
    else $error("stage one word lost while stalled");

  // Last byte of a packet is always a leaving byte inside a packet
  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser[0] && m_tuser[1] && !m_tuser[3]))
    else $error("packet last mark on an untagged byte");

endmodule

`default_nettype wire

@@ tb/delimited_packet_frame_sync_test.sv @@
// Testbench for the frame sync block: streams packets and noise, predicts every output word.
`timescale 1ns / 1ps

module delimited_packet_frame_sync_test;

  localparam int LATENCY     = 3;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 60;
  localparam int PHASE_BYTES = 544;

  // Bit positions of the fields in m_tdata
  localparam int SECS_LSB   = 1;
  localparam int MICROS_LSB = SECS_LSB + dpfs_pkg::SECS_W;
  localparam int BYTE_LSB   = MICROS_LSB + dpfs_pkg::MICROS_W;
  localparam int OFFS_LSB   = BYTE_LSB + 8;

  typedef struct packed {
    logic                          found;
    logic [dpfs_pkg::SECS_W-1:0]   secs;
    logic [dpfs_pkg::MICROS_W-1:0] micros;
    logic                          out_valid;
    dpfs_pkg::byte_t               out_byte;
    logic                          in_packet;
    dpfs_pkg::offset_t             offset;
    logic                          payload;
    logic                          first;
    logic                          last;
  } sync_word_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [dpfs_pkg::TDATA_W-1:0] m_tdata;
  logic [dpfs_pkg::TUSER_W-1:0] m_tuser;
  logic                         m_tlast;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [2:0]                   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // Stream bytes waiting to be sent and output words still owed by the block
  dpfs_pkg::byte_t byte_q[$];
  sync_word_t      expected_words[$];
  int unsigned     bytes_sent = 0;
  int unsigned     words_seen = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     stall_cycles = 0;

  // Shadow of the block: window ring, counters and delimiters
  dpfs_pkg::byte_t ring [dpfs_pkg::PACKET_BYTES];
  int unsigned     wr_pos = 0;
  bit              ring_full = 1'b0;
  int unsigned     since_hit = 0;
  int unsigned     drain_left = 0;
  logic [15:0]     start_delim = dpfs_pkg::START_RESET;
  logic [15:0]     end_delim = dpfs_pkg::END_RESET;

  dpfs_pkg::byte_t corner_bytes[] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                                      8'h0F, 8'hF0, 8'hB2, 8'h55, 8'h75, 8'h9F, 8'hB2, 8'h55,
                                      8'h00, 8'hFF};

  delimited_packet_frame_sync dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Window byte at position pos, 0 = oldest; zero beyond the window
  function automatic dpfs_pkg::byte_t window_at(int unsigned pos);
    int unsigned idx;
    if (pos >= dpfs_pkg::PACKET_BYTES) return 8'h00;
    idx = wr_pos + pos;
    if (idx >= dpfs_pkg::PACKET_BYTES) idx -= dpfs_pkg::PACKET_BYTES;
    return ring[idx];
  endfunction

  // Shift one byte into the shadow window and queue the word it causes
  function automatic void slide_window(dpfs_pkg::byte_t b);
    sync_word_t  w;
    int unsigned o;
    int          k;
    logic [31:0] nanos;
    w = '0;
    nanos = '0;
    if (ring_full) begin
      w.out_valid = 1'b1;
      w.out_byte = ring[wr_pos];
      if (drain_left > 0) begin
        o = dpfs_pkg::PACKET_BYTES - drain_left;
        w.in_packet = 1'b1;
        w.offset = o[dpfs_pkg::OFFSET_W-1:0];
        w.payload = (o >= dpfs_pkg::HEADER_BYTES + dpfs_pkg::STAMP_BYTES) &&
                    (o < dpfs_pkg::PACKET_BYTES - 2);
        w.first = (o == 0);
        w.last = (o == dpfs_pkg::PACKET_BYTES - 1);
        drain_left--;
      end
    end
    ring[wr_pos] = b;
    wr_pos++;
    if (wr_pos == dpfs_pkg::PACKET_BYTES) begin
      wr_pos = 0;
      ring_full = 1'b1;
    end
    if (since_hit < dpfs_pkg::PACKET_BYTES) since_hit++;
    // Check the window only once a full packet has entered since the last hit
    if (ring_full && since_hit == dpfs_pkg::PACKET_BYTES &&
        window_at(0) == start_delim[15:8] && window_at(1) == start_delim[7:0] &&
        window_at(dpfs_pkg::PACKET_BYTES - 2) == end_delim[15:8] &&
        window_at(dpfs_pkg::PACKET_BYTES - 1) == end_delim[7:0]) begin
      w.found = 1'b1;
      for (k = 0; k < dpfs_pkg::SECS_BYTES; k++)
        w.secs[8*k +: 8] = window_at(dpfs_pkg::HEADER_BYTES + k);
      for (k = 0; k < dpfs_pkg::NANOS_BYTES; k++)
        nanos[8*k +: 8] = window_at(dpfs_pkg::HEADER_BYTES + dpfs_pkg::SECS_BYTES + k);
      w.micros = dpfs_pkg::MICROS_W'(nanos / 32'd1000);
      drain_left = dpfs_pkg::PACKET_BYTES;
      since_hit = 0;
    end
    expected_words.push_back(w);
  endfunction

  function automatic bit take_break(int unsigned count);
    if (count >= 500 && count < 1000) return 1'b0;
    return $urandom_range(99) < 27;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (mismatch_count < PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  function automatic int unsigned add_noise(int unsigned n);
    repeat (n) byte_q.push_back(dpfs_pkg::byte_t'($urandom));
    return n;
  endfunction

  // Queue one packet under the current delimiters; a broken one has a bad
  // delimiter byte or a few payload bytes missing
  function automatic int unsigned add_packet(bit broken);
    dpfs_pkg::byte_t pkt[$];
    logic [63:0]     secs;
    logic [31:0]     nanos;
    int unsigned     pos;
    case ($urandom_range(3))
      0:       secs = '1;
      1:       secs = '0;
      default: secs = {$urandom, $urandom};
    endcase
    case ($urandom_range(4))
      0:       nanos = '1;
      1:       nanos = 32'd999_999_999;
      2:       nanos = '0;
      default: nanos = $urandom;
    endcase
    pkt.push_back(start_delim[15:8]);
    pkt.push_back(start_delim[7:0]);
    repeat (dpfs_pkg::HEADER_BYTES - 2) pkt.push_back(dpfs_pkg::byte_t'($urandom));
    for (int k = 0; k < dpfs_pkg::SECS_BYTES; k++) pkt.push_back(secs[8*k +: 8]);
    for (int k = 0; k < dpfs_pkg::NANOS_BYTES; k++) pkt.push_back(nanos[8*k +: 8]);
    repeat (dpfs_pkg::PACKET_BYTES - dpfs_pkg::HEADER_BYTES - dpfs_pkg::STAMP_TAPS - 2)
      pkt.push_back(dpfs_pkg::byte_t'($urandom));
    pkt.push_back(end_delim[15:8]);
    pkt.push_back(end_delim[7:0]);
    if (broken) begin
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(3))
          0:       pos = 0;
          1:       pos = 1;
          2:       pos = dpfs_pkg::PACKET_BYTES - 2;
          default: pos = dpfs_pkg::PACKET_BYTES - 1;
        endcase
        pkt[pos] = pkt[pos] ^ dpfs_pkg::byte_t'($urandom_range(255, 1));
      end else begin
        repeat ($urandom_range(8, 1))
          pkt.delete(dpfs_pkg::HEADER_BYTES + dpfs_pkg::STAMP_TAPS + 1);
      end
    end
    foreach (pkt[i]) byte_q.push_back(pkt[i]);
    return pkt.size();
  endfunction

  // Fill exactly budget bytes; a packet goes in only while a whole one still fits
  task automatic fill_phase(int unsigned budget);
    int unsigned count;
    int unsigned room;
    count = 0;
    while (count < budget) begin
      room = budget - count;
      if (room < dpfs_pkg::PACKET_BYTES) begin
        count += add_noise((room < 64) ? room : $urandom_range(64, 1));
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: count += add_packet(1'b0);
          5, 6:          count += add_packet(1'b1);
          default:       count += add_noise($urandom_range(64, 1));
        endcase
      end
    end
  endtask

  // Hold until every queued byte is sent and every owed word has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_q.size() != 0 || s_tvalid || expected_words.size() != 0);
  endtask

  task automatic write_reg(dpfs_pkg::reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dpfs_pkg::REG_START: start_delim = value;
      dpfs_pkg::REG_END:   end_delim = value;
    endcase
  endtask

  // Stimulus: corner bytes, then packet phases under several delimiter settings
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_bytes[i]) byte_q.push_back(corner_bytes[i]);
    fill_phase(PHASE_BYTES);
    wait_drained();
    write_reg(dpfs_pkg::REG_START, 16'hFFFF);
    write_reg(dpfs_pkg::REG_END, 16'h0000);
    fill_phase(PHASE_BYTES);
    wait_drained();
    write_reg(dpfs_pkg::REG_START, 16'h0000);
    write_reg(dpfs_pkg::REG_END, 16'hFFFF);
    fill_phase(PHASE_BYTES);
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Driver: predict on each accepted word, then offer the next byte or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        slide_window(s_tdata);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_q.size() != 0 && !take_break(bytes_sent)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output word with the oldest owed word
  always @(posedge clk) begin
    sync_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          if (mismatch_count < PRINT_LIMIT)
            $display("%0t: word with nothing owed, expected none, actual tdata %h", $time,
                     m_tdata);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("found", want.found, m_tdata[0]);
          check_field("stamp_seconds", want.secs, m_tdata[SECS_LSB +: dpfs_pkg::SECS_W]);
          check_field("stamp_micros", want.micros,
                      m_tdata[MICROS_LSB +: dpfs_pkg::MICROS_W]);
          check_field("out_valid", want.out_valid, m_tuser[0]);
          check_field("out_byte", want.out_byte, m_tdata[BYTE_LSB +: 8]);
          check_field("in_packet", want.in_packet, m_tuser[1]);
          check_field("byte_offset", want.offset, m_tdata[OFFS_LSB +: dpfs_pkg::OFFSET_W]);
          check_field("is_payload", want.payload, m_tuser[2]);
          check_field("packet_first", want.first, m_tuser[3]);
          check_field("packet_last", want.last, m_tlast);
        end
      end
      m_tready <= !take_break(words_seen);
    end
  end

  // Watchdog: end the run when neither side moves a word for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

@@ delimited_packet_frame_sync.f @@
design/dpfs_pkg.sv
design/dpfs_cell.sv
design/dpfs_ctrl.sv
design/delimited_packet_frame_sync.sv
tb/delimited_packet_frame_sync_test.sv
